>>> rtl/core/s2i_pkg.sv
// Shared types and constants for the string to integer parser.
// Holds the word formats of both channels, status codes and register indexes.
// No dependencies.
package s2i_pkg;

    // Longest string tracked; character indices saturate here.
    localparam int MAX_LEN = 4095;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);

    // Field widths fixed by the interface.
    localparam int CH_W    = 8;
    localparam int VALUE_W = 64;
    localparam int END_W   = 12;
    localparam int RADIX_W = 6;
    localparam int CFG_W   = RADIX_W;

    // Largest reported end offset.
    localparam int OFF_MAX = 4095;

    // Configuration register indexes.
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // One input word: a character and the end-of-string flag.
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [END_W-1:0]   end_offset;
    } t_out_word;

endpackage

>>> rtl/core/string_to_integer_parser.sv
// Top level of the string to integer parser.
// Depends on s2i_pkg for word formats, status codes and constants.
//
// Usage: the string arrives on the input channel one character per word, with
// last set on the final character. Leading white space is skipped, one sign
// is taken, and the digits are accumulated in the base set by the radix
// register (0 picks the base from a 0x or 0 prefix). After the word that
// carries last, one result word leaves on the output channel: the 64-bit
// value, a status and the offset of the first unparsed character.
// Both channels use valid and stall; a word moves at an edge where valid is
// high and stall is low. Configuration is written through a plain write port
// while the block is idle; radix is latched at the first character and
// signed_mode is sampled at the last one.
// Throughput is one character per cycle unless a stall holds the input, set
// by the digit step (a 64 by 6 bit multiply-add with an overflow check)
// between the input register and the state registers. A result word is
// formed as its last character leaves the input register. When the receiver
// stalls, the result waits in the output register; the input register keeps
// taking characters and only a further last character stalls the sender until
// the result is taken.
// Reset clears the parse state and sets radix to 10 and signed_mode to 1.
module string_to_integer_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  s2i_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output s2i_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [s2i_pkg::CFG_W-1:0]      i_cfg_data
);
    import s2i_pkg::*;

    typedef enum logic [2:0] {
        PH_WS, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS, PH_DONE
    } t_phase;

    localparam int PROD_W = VALUE_W + 7;
    localparam logic [RADIX_W-1:0] B8  = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] B10 = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] B16 = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] B36 = RADIX_W'(36);
    localparam logic [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Digit value of a character; 36 for anything that is not a digit.
    function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = B36;
        if (c >= "0" && c <= "9") d = RADIX_W'(c - "0");
        else if (c >= "a" && c <= "z") d = RADIX_W'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "Z") d = RADIX_W'(c - "A" + 8'd10);
        return d;
    endfunction

    // Configuration registers.
    logic [RADIX_W-1:0] r_radix;
    logic               r_signed;

    // Input register.
    logic     r_in_valid;
    t_in_word r_in;

    // Parse state.
    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_accum, n_accum;
    logic               r_neg, n_neg;
    logic [RADIX_W-1:0] r_eb, n_eb;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_stop, n_stop;
    logic               r_ovf, n_ovf;
    logic               r_perr, n_perr;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out, n_out;

    logic               proc;
    logic               take;
    logic [RADIX_W-1:0] dig;
    logic [IDX_W-1:0]   next_idx;
    logic [PROD_W-1:0]  prod;
    logic               prod_ovf;
    logic               is_ws;

    // The input register moves on unless it holds a last character and the
    // output register is still occupied.
    assign proc = r_in_valid && (!r_in.last || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign dig      = digit_of(r_in.ch);
    assign next_idx = (r_idx < IDX_W'(MAX_LEN)) ? r_idx + 1'b1 : IDX_W'(MAX_LEN);
    assign is_ws    = (r_in.ch == 8'd32) || (r_in.ch >= 8'd9 && r_in.ch <= 8'd13);

    // Phase logic: decides the new base and whether this character is a digit.
    always_comb begin
        n_phase = r_phase;
        n_eb    = r_eb;
        n_neg   = r_neg;
        n_perr  = r_perr;
        n_stop  = r_stop;
        take    = 1'b0;
        if (r_idx == '0 && r_phase == PH_WS) begin
            n_eb = r_radix;
            if (r_radix == RADIX_W'(1) || r_radix > B36) begin
                n_perr  = 1'b1;
                n_phase = PH_DONE;
            end
        end
        unique case (n_phase)
            PH_WS, PH_SIGN: begin
                if (n_phase == PH_WS && is_ws) begin
                    n_phase = PH_WS;
                end else if (n_phase == PH_WS && r_in.ch == "+") begin
                    n_phase = PH_SIGN;
                end else if (n_phase == PH_WS && r_in.ch == "-") begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGN;
                end else if ((n_eb == '0 || n_eb == B16) && r_in.ch == "0") begin
                    n_stop  = next_idx;
                    n_phase = PH_ZERO;
                end else begin
                    if (n_eb == '0) n_eb = B10;
                    if (dig < n_eb) take = 1'b1;
                    else begin
                        n_perr  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_ZERO: begin
                if (r_in.ch == "x" || r_in.ch == "X") begin
                    n_phase = PH_X;
                end else begin
                    if (n_eb == '0) n_eb = B8;
                    if (dig < n_eb) take = 1'b1;
                    else n_phase = PH_DONE;
                end
            end
            PH_X: begin
                n_eb = B16;
                if (dig < B16) take = 1'b1;
                else n_phase = PH_DONE;
            end
            PH_DIGITS: begin
                if (dig < n_eb) take = 1'b1;
                else n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        if (take) begin
            n_stop  = next_idx;
            n_phase = PH_DIGITS;
        end
    end

    // Digit step: accum * base + digit, saturating when it leaves 64 bits.
    assign prod     = PROD_W'(r_accum) * PROD_W'((n_eb == '0) ? B10 : n_eb)
                    + PROD_W'(dig);
    assign prod_ovf = |prod[PROD_W-1:VALUE_W];

    always_comb begin
        n_accum = r_accum;
        n_ovf   = r_ovf;
        n_idx   = next_idx;
        if (take) begin
            n_accum = prod_ovf ? {VALUE_W{1'b1}} : prod[VALUE_W-1:0];
            n_ovf   = r_ovf || prod_ovf;
        end
    end

    // Result formation for the last character.
    always_comb begin
        n_out.value      = '0;
        n_out.status     = ST_OK;
        n_out.end_offset = '0;
        if (n_perr || n_phase == PH_WS || n_phase == PH_SIGN) begin
            n_out.status = ST_INVALID;
        end else begin
            n_out.end_offset = (32'(n_stop) > 32'(OFF_MAX)) ? END_W'(OFF_MAX)
                                                           : END_W'(n_stop);
            if (r_signed) begin
                if (!n_neg) begin
                    if (n_ovf || n_accum > INT_MAX) begin
                        n_out.value  = INT_MAX;
                        n_out.status = ST_RANGE;
                    end else begin
                        n_out.value = n_accum;
                    end
                end else begin
                    if (n_ovf || n_accum > INT_MIN) begin
                        n_out.value  = INT_MIN;
                        n_out.status = ST_RANGE;
                    end else begin
                        n_out.value = '0 - n_accum;
                    end
                end
            end else if (n_ovf) begin
                n_out.value  = {VALUE_W{1'b1}};
                n_out.status = ST_RANGE;
            end else begin
                n_out.value = n_neg ? '0 - n_accum : n_accum;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= B10;
            r_signed <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIX:  r_radix  <= i_cfg_data;
                REG_SIGNED: r_signed <= i_cfg_data[0];
                default:    r_radix  <= r_radix;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) r_in <= i_in_word;
    end

    // Parse state: cleared after each string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_in.last)) begin
            r_phase <= PH_WS;
            r_accum <= '0;
            r_neg   <= 1'b0;
            r_eb    <= '0;
            r_idx   <= '0;
            r_stop  <= '0;
            r_ovf   <= 1'b0;
            r_perr  <= 1'b0;
        end else if (proc) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_neg   <= n_neg;
            r_eb    <= n_eb;
            r_idx   <= n_idx;
            r_stop  <= n_stop;
            r_ovf   <= n_ovf;
            r_perr  <= n_perr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_in.last) r_out <= n_out;
    end

    // An invalid result carries neither a value nor an offset.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_INVALID
        |-> o_out_word.value == '0 && o_out_word.end_offset == '0)
        else $error("invalid result with nonzero value or offset");

    // The parse state is back at the start after a string ends.
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.last |=> r_phase == PH_WS && r_idx == '0 && r_accum == '0)
        else $error("parse state not cleared after last character");

    // A new result only follows a processed last character.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !($past(r_out_valid) && $past(i_out_stall))
        |-> $past(proc && r_in.last))
        else $error("result without a last character");

endmodule

>>> verif/tb_string_to_integer_parser.sv
// Testbench for the string to integer parser: directed strings, then random
// strings under many radix and sign settings, checked against an in-bench model.
// Depends on s2i_pkg and the string_to_integer_parser RTL.
module tb_string_to_integer_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import s2i_pkg::*;

    // Parse phases of the in-bench model.
    typedef enum logic [2:0] {
        PS_WS, PS_SIGN, PS_ZERO, PS_X, PS_DIGITS, PS_DONE
    } t_parse_phase;

    localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT64_MIN = {1'b1, 63'd0};
    localparam logic [11:0] IDX_MAX   = 12'(MAX_LEN);
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_CR     = 8'h0d;
    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam int          HOLD_LEN  = 300;
    localparam int          PHASE_CHARS = 75;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_idx   = REG_RADIX;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    string_to_integer_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Words waiting to be sent and parse results waiting to arrive.
    t_in_word  char_queue[$];
    t_out_word expected_parses[$];

    // Register copies and model state.
    logic [5:0]   cur_radix  = 6'd10;
    logic         cur_signed = 1'b1;
    t_parse_phase m_phase    = PS_WS;
    logic [63:0]  m_accum    = '0;
    logic         m_negative = 1'b0;
    logic [5:0]   m_base     = '0;
    logic [11:0]  m_char_idx = '0;
    logic [11:0]  m_stop_idx = '0;
    logic         m_overflow = 1'b0;
    logic         m_error    = 1'b0;

    // Run control and bookkeeping.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int strings_queued  = 0;
    int chars_queued    = 0;
    int settings_used   = 0;
    int status_seen[4]  = '{0, 0, 0, 0};

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // One line per mismatch; printing stops after a while but counting goes on.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
    endtask

    // ------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------

    function automatic logic [5:0] digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return 6'(c - "0");
        if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd10);
        if (c >= "A" && c <= "Z") return 6'(c - "A" + 8'd10);
        return 6'd36;
    endfunction

    // Multiply-add with saturation on overflow.
    function automatic void accumulate_digit(logic [5:0] d, logic [11:0] nxt);
        logic [63:0] b;
        logic [63:0] limit;
        b = (m_base != 0) ? 64'(m_base) : 64'd10;
        limit = ({64{1'b1}} - 64'(d)) / b;
        if (m_accum > limit) begin
            m_accum = '1;
            m_overflow = 1'b1;
        end else begin
            m_accum = m_accum * b + 64'(d);
        end
        m_stop_idx = nxt;
        m_phase = PS_DIGITS;
    endfunction

    // First character after white space and sign.
    function automatic void start_number(logic [7:0] c, logic [5:0] d, logic [11:0] nxt);
        if ((m_base == 0 || m_base == 16) && c == "0") begin
            m_accum = '0;
            m_stop_idx = nxt;
            m_phase = PS_ZERO;
            return;
        end
        if (m_base == 0) m_base = 6'd10;
        if (d < m_base) begin
            m_accum = '0;
            accumulate_digit(d, nxt);
        end else begin
            m_error = 1'b1;
            m_phase = PS_DONE;
        end
    endfunction

    // Advance the model by one accepted word; a last word yields a result.
    function automatic void parse_char(t_in_word w);
        logic [7:0]  c;
        logic [5:0]  d;
        logic [11:0] nxt;
        t_out_word   r;
        c = w.ch;
        d = digit_value(c);
        nxt = (m_char_idx < IDX_MAX) ? m_char_idx + 12'd1 : IDX_MAX;

        // The radix is latched on the first character of a string.
        if (m_char_idx == 0 && m_phase == PS_WS) begin
            m_base = cur_radix;
            if (cur_radix == 1 || cur_radix > 36) begin
                m_error = 1'b1;
                m_phase = PS_DONE;
            end
        end

        case (m_phase)
            PS_WS: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    // Leading white space is skipped.
                end else if (c == "+") begin
                    m_phase = PS_SIGN;
                end else if (c == "-") begin
                    m_negative = 1'b1;
                    m_phase = PS_SIGN;
                end else begin
                    start_number(c, d, nxt);
                end
            end
            PS_SIGN: start_number(c, d, nxt);
            PS_ZERO: begin
                if (c == "x" || c == "X") begin
                    m_phase = PS_X;
                end else begin
                    if (m_base == 0) m_base = 6'd8;
                    if (d < m_base) accumulate_digit(d, nxt);
                    else m_phase = PS_DONE;
                end
            end
            PS_X: begin
                m_base = 6'd16;
                if (d < 16) accumulate_digit(d, nxt);
                else m_phase = PS_DONE;
            end
            PS_DIGITS: begin
                if (d < m_base) accumulate_digit(d, nxt);
                else m_phase = PS_DONE;
            end
            default: ;
        endcase
        m_char_idx = nxt;

        if (!w.last) return;

        // Build the result; signed_mode is taken at the last character.
        r = '0;
        r.status = ST_OK;
        if (m_error || m_phase == PS_WS || m_phase == PS_SIGN) begin
            r.status = ST_INVALID;
        end else begin
            r.end_offset = m_stop_idx;
            if (cur_signed) begin
                if (!m_negative) begin
                    if (m_overflow || m_accum > INT64_MAX) begin
                        r.value = INT64_MAX;
                        r.status = ST_RANGE;
                    end else begin
                        r.value = m_accum;
                    end
                end else if (m_overflow || m_accum > INT64_MIN) begin
                    r.value = INT64_MIN;
                    r.status = ST_RANGE;
                end else begin
                    r.value = -m_accum;
                end
            end else if (m_overflow) begin
                r.value = '1;
                r.status = ST_RANGE;
            end else begin
                r.value = m_negative ? -m_accum : m_accum;
            end
        end
        expected_parses.push_back(r);

        m_phase = PS_WS;
        m_accum = '0;
        m_negative = 1'b0;
        m_base = '0;
        m_char_idx = '0;
        m_stop_idx = '0;
        m_overflow = 1'b0;
        m_error = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends queued characters, holds a stalled word steady
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_chars
        logic     nxt_valid;
        t_in_word nxt_word;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_word = i_in_word;
            if (i_in_valid && !o_in_stall) begin
                parse_char(i_in_word);
                void'(char_queue.pop_front());
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && char_queue.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_word = char_queue[0];
            end
            i_in_valid <= nxt_valid;
            i_in_word <= nxt_word;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word and drives the receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                status_seen[o_out_word.status]++;
                if (expected_parses.size() == 0) begin
                    report_mismatch("unexpected result value", o_out_word.value, '0);
                end else begin
                    want = expected_parses.pop_front();
                    if (o_out_word.value !== want.value)
                        report_mismatch("value", o_out_word.value, want.value);
                    if (o_out_word.status !== want.status)
                        report_mismatch("status", 64'(o_out_word.status), 64'(want.status));
                    if (o_out_word.end_offset !== want.end_offset)
                        report_mismatch("end_offset", 64'(o_out_word.end_offset),
                                        64'(want.end_offset));
                end
            end

            // A requested hold-off is counted here, cycle by cycle.
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_byte(logic [7:0] c, logic lst);
        t_in_word w;
        w.ch = c;
        w.last = lst;
        char_queue.push_back(w);
        chars_queued++;
        if (lst) strings_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], i == s.len() - 1);
    endtask

    // Wait until every word is sent and every result is back, then let the
    // pipeline settle before anything touches the registers.
    task automatic wait_idle();
        while (char_queue.size() != 0 || i_in_valid || expected_parses.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_RADIX) cur_radix = data;
        else cur_signed = data[0];
    endtask

    task automatic set_config(logic [5:0] rdx, logic sgn);
        wait_idle();
        write_reg(REG_RADIX, rdx);
        write_reg(REG_SIGNED, CFG_W'(sgn));
        settings_used++;
    endtask

    function automatic logic [7:0] digit_char(int d);
        if (d < 10) return 8'("0" + d);
        if ($urandom_range(1)) return 8'("a" + d - 10);
        return 8'("A" + d - 10);
    endfunction

    // Mostly well-formed numbers with random content; some broken, some noise.
    task automatic queue_random_string(logic [5:0] rdx);
        logic [7:0] buf_q[$];
        int kind;
        int base;
        int n;
        kind = $urandom_range(99);
        base = (rdx >= 2 && rdx <= 36) ? int'(rdx) : 10;
        if (kind >= 88) begin
            repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(0, 2))
                buf_q.push_back($urandom_range(5) == 0 ? CH_SPACE
                                                       : 8'(9 + $urandom_range(4)));
            case ($urandom_range(3))
                1: buf_q.push_back("+");
                2: buf_q.push_back("-");
                default: ;
            endcase
            if (rdx == 0) begin
                case ($urandom_range(3))
                    0: begin
                        buf_q.push_back("0");
                        buf_q.push_back($urandom_range(1) ? "x" : "X");
                        base = 16;
                    end
                    1: begin
                        buf_q.push_back("0");
                        base = 8;
                    end
                    default: ;
                endcase
            end else if (rdx == 16 && $urandom_range(1)) begin
                buf_q.push_back("0");
                buf_q.push_back($urandom_range(1) ? "x" : "X");
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(12, 70) : $urandom_range(1, 8);
            // Broken numbers: no digits at all, or a stray byte before them.
            if (kind >= 75) begin
                if ($urandom_range(1)) n = 0;
                else buf_q.push_back(8'($urandom_range(255)));
            end
            repeat (n) buf_q.push_back(digit_char($urandom_range(base - 1)));
            if (base < 36 && $urandom_range(2) == 0) buf_q.push_back(digit_char(base));
            repeat ($urandom_range(0, 2)) buf_q.push_back(8'($urandom_range(255)));
        end
        if (buf_q.size() == 0) buf_q.push_back(8'($urandom_range(255)));
        foreach (buf_q[i]) queue_byte(buf_q[i], i == buf_q.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        logic [5:0] radix_plan[12];
        int         first_char;
        radix_plan = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd8,
                       6'd1, 6'd37, 6'd63, 6'd0, 6'd0, 6'd0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset settings (radix 10, signed).
        queue_text("\t+123");
        queue_text("-");
        queue_text(" ");
        queue_text("q7");
        queue_byte("1", 1'b0);
        queue_byte(CH_NUL, 1'b0);
        queue_byte("5", 1'b1);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h0b, 1'b0);
        queue_text("9z 12");
        queue_text("-0");

        // Automatic base: hex, octal, bare 0x, bad hex digit, bad octal digit.
        set_config(6'd0, 1'b1);
        queue_text("0x1f");
        queue_text("017");
        queue_text("0x");
        queue_text("0Xg");
        queue_text("08");

        set_config(6'd16, 1'b1);
        queue_text("0XfF");
        queue_text("0xz");

        // Overflow and negation in both modes.
        set_config(6'd36, 1'b1);
        queue_text("zzzzzzzzzzzzz");
        queue_text("-zzzzzzzzzzzzz");
        set_config(6'd36, 1'b0);
        queue_text("-zz");
        queue_text("zzzzzzzzzzzzz");

        // Invalid radix values, then a bad digit in base 2.
        set_config(6'd1, 1'b1);
        queue_text("5");
        set_config(6'd37, 1'b0);
        queue_text("5");
        set_config(6'd2, 1'b1);
        queue_text("1012");

        // Random phases over radix and sign settings and idling patterns.
        for (int p = 0; p < 12; p++) begin
            if (p == 9) radix_plan[p] = 6'($urandom_range(2, 36));
            if (p == 11) radix_plan[p] = 6'($urandom_range(63));
            set_config(radix_plan[p], (p % 3) != 0);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            first_char = chars_queued;
            while (chars_queued - first_char < PHASE_CHARS)
                queue_random_string(cur_radix);
        end

        // Long receiver hold-off while the sender keeps offering strings.
        set_config(6'd10, 1'b1);
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (40) queue_random_string(cur_radix);

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("tb: %0d strings, %0d characters, %0d register settings, %0d results checked",
                 strings_queued, chars_queued, settings_used, results_checked);
        $display("tb: statuses seen: ok %0d, out of range %0d, invalid %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_INVALID]);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/s2i_pkg.sv
rtl/core/string_to_integer_parser.sv
verif/tb_string_to_integer_parser.sv
